// ----- rtl/core/lcid_pkg.sv -----
// shared types and constants of the link context id table
`default_nettype none

package lcid_pkg;

   localparam int ENTRIES_DEF = 64;
   localparam int SLOT_W      = 6;
   localparam int DATA_W      = 32;

   // all ones marks a free entry, also the unset peer id
   localparam logic signed [DATA_W-1:0] FREE_MARK = '1;

   typedef enum logic [2:0] {
      CMD_ALLOC       = 3'd0,
      CMD_RELEASE     = 3'd1,
      CMD_FIND_PAIR   = 3'd2,
      CMD_FIND_SOURCE = 3'd3,
      CMD_FIND_TARGET = 3'd4,
      CMD_FIND_VALUE  = 3'd5,
      CMD_SET         = 3'd6,
      CMD_READ        = 3'd7
   } cmd_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] ue_value;
      logic signed [DATA_W-1:0] source_id;
      logic signed [DATA_W-1:0] target_id;
   } entry_type;

   typedef struct packed {
      cmd_type                  command;
      logic [SLOT_W-1:0]        slot;
      logic signed [DATA_W-1:0] ue_value;
      logic signed [DATA_W-1:0] source_id;
      logic signed [DATA_W-1:0] target_id;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic [SLOT_W-1:0]        result_slot;
      logic signed [DATA_W-1:0] entry_value;
      logic signed [DATA_W-1:0] entry_source;
      logic signed [DATA_W-1:0] entry_target;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/lcid_ifs.sv -----
// request and response channel interfaces of the link context id table
`default_nettype none

interface lcid_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         command;
   logic [5:0]         slot;
   logic signed [31:0] ue_value;
   logic signed [31:0] source_id;
   logic signed [31:0] target_id;

   modport source (output valid, command, slot, ue_value, source_id, target_id,
                   input ready);
   modport sink   (input valid, command, slot, ue_value, source_id, target_id,
                   output ready);
endinterface

interface lcid_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic [5:0]         result_slot;
   logic signed [31:0] entry_value;
   logic signed [31:0] entry_source;
   logic signed [31:0] entry_target;

   modport source (output valid, found, result_slot, entry_value, entry_source,
                   entry_target, input ready);
   modport sink   (input valid, found, result_slot, entry_value, entry_source,
                   entry_target, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lcid_store.sv -----
// entry memory: one write port, one registered read port
`default_nettype none

module lcid_store #(
   parameter int ENTRIES = lcid_pkg::ENTRIES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  wire lcid_pkg::entry_type        wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
   output      lcid_pkg::entry_type        rd_data
);

   lcid_pkg::entry_type mem [ENTRIES];
   lcid_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/lcid_seq.sv -----
// command sequencer: clearing pass, slot access and linear scan over the memory
`default_nettype none

module lcid_seq #(
   parameter int ENTRIES = lcid_pkg::ENTRIES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire lcid_pkg::req_type          req_data,
   output      logic                       res_valid,
   input  wire logic                       res_ready,
   output      lcid_pkg::rsp_type          res_data,
   output      logic                       wr_en,
   output      logic [$clog2(ENTRIES)-1:0] wr_addr,
   output      lcid_pkg::entry_type        wr_data,
   output      logic                       rd_en,
   output      logic [$clog2(ENTRIES)-1:0] rd_addr,
   input  wire lcid_pkg::entry_type        rd_data
);

   localparam int AW = $clog2(ENTRIES);
   localparam int IW = AW + 1;
   localparam int XW = (AW > lcid_pkg::SLOT_W) ? AW : lcid_pkg::SLOT_W;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SLOT  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   lcid_pkg::req_type  cmd_ff, cmd_in;
   lcid_pkg::rsp_type  res_ff, res_in;

   logic [XW-1:0]      req_slot_x;
   logic [XW-1:0]      cmd_slot_x;
   logic [XW-1:0]      rd_idx_x;
   logic               req_slot_ok;
   logic               cmd_slot_ok;
   logic               used;
   logic               hit;

   assign req_slot_x  = XW'(req_data.slot);
   assign cmd_slot_x  = XW'(cmd_ff.slot);
   assign rd_idx_x    = XW'(rd_idx_ff);
   assign req_slot_ok = 32'(req_data.slot) < 32'(ENTRIES);
   assign cmd_slot_ok = 32'(cmd_ff.slot) < 32'(ENTRIES);

   assign used = rd_data.ue_value != lcid_pkg::FREE_MARK;

   always_comb begin
      case (cmd_ff.command)
         lcid_pkg::CMD_ALLOC:       hit = !used;
         lcid_pkg::CMD_FIND_PAIR:   hit = used && rd_data.source_id == cmd_ff.source_id
                                           && rd_data.target_id == cmd_ff.target_id;
         lcid_pkg::CMD_FIND_SOURCE: hit = used && rd_data.source_id == cmd_ff.source_id;
         lcid_pkg::CMD_FIND_TARGET: hit = used && rd_data.target_id == cmd_ff.target_id;
         lcid_pkg::CMD_FIND_VALUE:  hit = rd_data.ue_value == cmd_ff.ue_value;
         default:                   hit = 1'b0;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = rd_idx_ff;
      cmd_in      = cmd_ff;
      res_in      = res_ff;
      rd_en       = 1'b0;
      rd_addr     = idx_ff[AW-1:0];
      wr_en       = 1'b0;
      wr_addr     = rd_idx_ff;
      wr_data     = rd_data;
      req_ready   = 1'b0;
      res_valid   = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = '{ue_value: lcid_pkg::FREE_MARK, source_id: '0, target_id: '0};
            if (idx_ff == IW'(ENTRIES - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in = req_data;
               if (req_data.command == lcid_pkg::CMD_RELEASE ||
                   req_data.command == lcid_pkg::CMD_SET ||
                   req_data.command == lcid_pkg::CMD_READ) begin
                  rd_en    = req_slot_ok;
                  rd_addr  = req_slot_x[AW-1:0];
                  state_in = ST_SLOT;
               end else begin
                  rd_en       = 1'b1;
                  rd_addr     = '0;
                  rd_idx_in   = '0;
                  rd_valid_in = 1'b1;
                  idx_in      = IW'(1);
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SLOT: begin
            res_in.found       = cmd_slot_ok;
            res_in.result_slot = cmd_ff.slot;
            wr_addr            = cmd_slot_x[AW-1:0];
            if (!cmd_slot_ok) begin
               wr_data = '0;
            end else begin
               case (cmd_ff.command)
                  lcid_pkg::CMD_RELEASE: begin
                     wr_en   = 1'b1;
                     wr_data = '{ue_value: lcid_pkg::FREE_MARK,
                                 source_id: rd_data.source_id,
                                 target_id: rd_data.target_id};
                  end
                  lcid_pkg::CMD_SET: begin
                     wr_en   = 1'b1;
                     wr_data = '{ue_value: cmd_ff.ue_value,
                                 source_id: cmd_ff.source_id,
                                 target_id: cmd_ff.target_id};
                  end
                  default: begin
                     wr_data = rd_data;
                  end
               endcase
            end
            res_in.entry_value  = wr_data.ue_value;
            res_in.entry_source = wr_data.source_id;
            res_in.entry_target = wr_data.target_id;
            state_in            = ST_RESP;
         end
         ST_SCAN: begin
            if (rd_valid_ff && hit) begin
               if (cmd_ff.command == lcid_pkg::CMD_ALLOC) begin
                  wr_en   = 1'b1;
                  wr_data = '{ue_value: '0,
                              source_id: lcid_pkg::FREE_MARK,
                              target_id: lcid_pkg::FREE_MARK};
               end
               res_in.found        = 1'b1;
               res_in.result_slot  = rd_idx_x[lcid_pkg::SLOT_W-1:0];
               res_in.entry_value  = wr_data.ue_value;
               res_in.entry_source = wr_data.source_id;
               res_in.entry_target = wr_data.target_id;
               state_in            = ST_RESP;
            end else if (!rd_valid_ff) begin
               res_in   = '0;
               state_in = ST_RESP;
            end else if (idx_ff < IW'(ENTRIES)) begin
               rd_en       = 1'b1;
               rd_addr     = idx_ff[AW-1:0];
               rd_idx_in   = idx_ff[AW-1:0];
               rd_valid_in = 1'b1;
               idx_in      = idx_ff + IW'(1);
            end
         end
         ST_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         idx_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      cmd_ff    <= cmd_in;
      res_ff    <= res_in;
   end

   assign res_data = res_ff;

endmodule

`default_nettype wire

// ----- rtl/core/link_context_id_table.sv -----
// link context id table: slot allocator with first-match lookup over a memory
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+--------------------------------------------
//   req     | in  | req.valid/ready   | command, slot, ue_value, source_id, target_id
//   rsp     | out | rsp.valid/ready   | found, result_slot, entry_value/source/target
//
// release, set and read go from accept to the response register through a memory
//   read, the update and the hand-off; allocate and the searches scan the memory from
//   entry 0 one entry a cycle, set by the single memory read port
// after reset a clearing pass writes every entry before req.ready rises
// the response register holds an item while rsp.ready is low; the next item is
//   still taken and waits in the sequencer until that register frees
`default_nettype none

module link_context_id_table #(
   parameter int ENTRIES = lcid_pkg::ENTRIES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lcid_req_if.sink   req,
   lcid_rsp_if.source rsp
);

   localparam int AW = $clog2(ENTRIES);

   // sequencer side
   lcid_pkg::req_type   req_data;
   lcid_pkg::rsp_type   res_data;
   logic                res_valid;
   logic                res_ready;

   // memory ports
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   lcid_pkg::entry_type wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   lcid_pkg::entry_type rd_data;

   // response register
   logic                out_valid_ff, out_valid_in;
   lcid_pkg::rsp_type   out_ff;

   assign req_data = '{command:   lcid_pkg::cmd_type'(req.command),
                       slot:      req.slot,
                       ue_value:  req.ue_value,
                       source_id: req.source_id,
                       target_id: req.target_id};

   lcid_seq #(
      .ENTRIES (ENTRIES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   lcid_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // response register takes a new item when empty or being drained
   assign res_ready = !out_valid_ff || rsp.ready;

   always_comb begin
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_ff <= res_data;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.found        = out_ff.found;
   assign rsp.result_slot  = out_ff.result_slot;
   assign rsp.entry_value  = out_ff.entry_value;
   assign rsp.entry_source = out_ff.entry_source;
   assign rsp.entry_target = out_ff.entry_target;

endmodule

`default_nettype wire
